@@ rtl/block_pool_mailbox_manager_unit_macros.svh @@
// Assertion macros for the block pool mailbox manager.
// Taken in by the files that assert; needs nothing else.
`ifndef BLOCK_POOL_MAILBOX_MANAGER_UNIT_MACROS_SVH
`define BLOCK_POOL_MAILBOX_MANAGER_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BPM_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define BPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bpm_pkg.sv @@
// Shared types and constants of the block pool mailbox manager.
// No dependencies.
package bpm_pkg;

    localparam int BPM_BLOCK_COUNT_DEF = 16;
    localparam int BPM_BLOCK_SIZE_DEF  = 4096;

    // Fixed widths of the word fields
    localparam int REQ_W     = 16;
    localparam int IDX_W     = 4;
    localparam int AMT_OUT_W = 13;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } t_req_type;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
    } t_bpm_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_bpm_sts;

endpackage

@@ rtl/bpm_channels.sv @@
// Request and response channel interfaces of the block pool mailbox manager.
// Depends on bpm_pkg.
interface bpm_req_if import bpm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_req_type            req_type;
    logic [REQ_W-1:0]     request_amount;
    logic [REQ_W-1:0]     reader_capacity;

    modport source (output valid, output req_type, output request_amount,
                    output reader_capacity, input ready);
    modport sink   (input valid, input req_type, input request_amount,
                    input reader_capacity, output ready);
endinterface

interface bpm_rsp_if import bpm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [IDX_W-1:0]     block_index;
    logic [AMT_OUT_W-1:0] amount_out;

    modport source (output valid, output ok, output block_index, output amount_out,
                    input ready);
    modport sink   (input valid, input ok, input block_index, input amount_out,
                    output ready);
endinterface

@@ rtl/bpm_ctrl.sv @@
// Controller of the block pool mailbox manager: link clear, accept, execute.
// Depends on bpm_pkg and the assertion macros header.
`include "block_pool_mailbox_manager_unit_macros.svh"

module bpm_ctrl import bpm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_bpm_cmd o_cmd,
    input  t_bpm_sts i_sts
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;

    always_comb begin
        n_state          = r_state;
        o_cmd.clear_step = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.exec       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `BPM_ASSERT_NEXT(a_accept_then_exec, i_clk, i_rst_n, o_cmd.accept, o_cmd.exec, "accept not followed by execute")
    `BPM_ASSERT_HOLDS(a_no_accept_in_clear, i_clk, i_rst_n, !(o_cmd.accept && o_cmd.clear_step), "accept during link clear")
    `BPM_ASSERT_NEXT(a_exec_once, i_clk, i_rst_n, o_cmd.exec, !o_cmd.exec, "execute held two cycles")

endmodule

@@ rtl/bpm_dpath.sv @@
// Datapath of the block pool mailbox manager: list heads, link and amount
// memories, result register. Depends on bpm_pkg and the assertion macros header.
`include "block_pool_mailbox_manager_unit_macros.svh"

module bpm_dpath import bpm_pkg::*; #(
    parameter int BLOCK_COUNT = BPM_BLOCK_COUNT_DEF,
    parameter int BLOCK_SIZE  = BPM_BLOCK_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_bpm_cmd             i_cmd,
    output t_bpm_sts             o_sts,
    input  t_req_type            i_req_type,
    input  logic [REQ_W-1:0]     i_request_amount,
    input  logic [REQ_W-1:0]     i_reader_capacity,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_ok,
    output logic [IDX_W-1:0]     o_block_index,
    output logic [AMT_OUT_W-1:0] o_amount_out
);

    localparam int LW = $clog2(BLOCK_COUNT + 1);
    localparam int IW = $clog2(BLOCK_COUNT);
    localparam int AW = $clog2(BLOCK_SIZE + 1);
    localparam logic [LW-1:0]    NULL_LINK = LW'(BLOCK_COUNT);
    localparam logic [IW-1:0]    LAST_IDX  = IW'(BLOCK_COUNT - 1);
    localparam logic [REQ_W-1:0] SIZE_CAP  = REQ_W'(BLOCK_SIZE);

    logic [LW-1:0] r_link_mem [BLOCK_COUNT];
    logic [AW-1:0] r_amt_mem  [BLOCK_COUNT];

    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_queue_head, n_queue_head;
    logic [LW-1:0] r_queue_tail, n_queue_tail;
    logic [IW-1:0] r_clr_cnt;

    t_req_type        r_req_type;
    logic [REQ_W-1:0] r_req_amount;
    logic [REQ_W-1:0] r_req_cap;
    logic [LW-1:0]    r_link_rd;
    logic [AW-1:0]    r_amt_rd;

    logic                 r_out_valid;
    logic                 r_ok, n_ok;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [AMT_OUT_W-1:0] r_amt, n_amt;

    logic             free_ok, queue_ok, tail_ok, rd_ok, is_rd, wr_go, rd_go;
    logic [LW-1:0]    rd_ptr;
    logic [REQ_W-1:0] clip, stored, deliver;
    logic             lk_we;
    logic [IW-1:0]    lk_addr;
    logic [LW-1:0]    lk_data;

    assign free_ok  = r_free_head < NULL_LINK;
    assign queue_ok = r_queue_head < NULL_LINK;
    assign tail_ok  = r_queue_tail < NULL_LINK;
    assign rd_ptr   = (i_req_type == REQ_READ) ? r_queue_head : r_free_head;
    assign rd_ok    = rd_ptr < NULL_LINK;
    assign is_rd    = (r_req_type == REQ_READ);
    assign wr_go    = i_cmd.exec && !is_rd && free_ok;
    assign rd_go    = i_cmd.exec && is_rd && queue_ok;

    assign clip    = (r_req_amount < SIZE_CAP) ? r_req_amount : SIZE_CAP;
    assign stored  = REQ_W'(r_amt_rd);
    assign deliver = (stored < r_req_cap) ? stored : r_req_cap;

    // One link write a cycle: clear sweep, tail append, or push to free stack
    always_comb begin
        lk_we   = 1'b0;
        lk_addr = r_clr_cnt;
        lk_data = LW'(r_clr_cnt) + LW'(1);
        priority if (i_cmd.clear_step) begin
            lk_we = 1'b1;
        end else if (wr_go && tail_ok) begin
            lk_we   = 1'b1;
            lk_addr = r_queue_tail[IW-1:0];
            lk_data = r_free_head;
        end else if (rd_go) begin
            lk_we   = 1'b1;
            lk_addr = r_queue_head[IW-1:0];
            lk_data = r_free_head;
        end else begin
            lk_we = 1'b0;
        end
    end

    always_comb begin
        n_free_head  = r_free_head;
        n_queue_head = r_queue_head;
        n_queue_tail = r_queue_tail;
        n_ok         = 1'b0;
        n_idx        = '0;
        n_amt        = '0;
        if (wr_go) begin
            n_free_head  = r_link_rd;
            n_queue_tail = r_free_head;
            if (!queue_ok) begin
                n_queue_head = r_free_head;
            end
            n_ok  = 1'b1;
            n_idx = IDX_W'(r_free_head);
            n_amt = AMT_OUT_W'(clip);
        end else if (rd_go) begin
            // The tail's link is never followed: the list ends there
            if (r_queue_head == r_queue_tail) begin
                n_queue_head = NULL_LINK;
                n_queue_tail = NULL_LINK;
            end else begin
                n_queue_head = r_link_rd;
            end
            n_free_head = r_queue_head;
            n_ok        = 1'b1;
            n_idx       = IDX_W'(r_queue_head);
            n_amt       = AMT_OUT_W'(deliver);
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_link_mem[lk_addr] <= lk_data;
        end
        if (i_cmd.accept && rd_ok) begin
            r_link_rd <= r_link_mem[rd_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_amt_mem[r_free_head[IW-1:0]] <= AW'(clip);
        end
        if (i_cmd.accept && rd_ok && (i_req_type == REQ_READ)) begin
            r_amt_rd <= r_amt_mem[rd_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type   <= i_req_type;
            r_req_amount <= i_request_amount;
            r_req_cap    <= i_reader_capacity;
        end
        if (i_cmd.exec) begin
            r_ok  <= n_ok;
            r_idx <= n_idx;
            r_amt <= n_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= '0;
            r_queue_head <= NULL_LINK;
            r_queue_tail <= NULL_LINK;
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_free_head  <= n_free_head;
            r_queue_head <= n_queue_head;
            r_queue_tail <= n_queue_tail;
            if (i_cmd.clear_step && (r_clr_cnt != LAST_IDX)) begin
                r_clr_cnt <= r_clr_cnt + IW'(1);
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_done = (r_clr_cnt == LAST_IDX);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_ok;
    assign o_block_index    = r_idx;
    assign o_amount_out     = r_amt;

    `BPM_ASSERT_HOLDS(a_exec_slot_free, i_clk, i_rst_n, !(i_cmd.exec && r_out_valid), "result register overwritten")
    `BPM_ASSERT_HOLDS(a_queue_ends_agree, i_clk, i_rst_n, queue_ok == tail_ok, "queue head and tail disagree on empty")
    `BPM_ASSERT_HOLDS(a_lists_disjoint, i_clk, i_rst_n, !(free_ok && queue_ok && (r_free_head == r_queue_head)), "block on both lists")

endmodule

@@ rtl/block_pool_mailbox_manager_unit.sv @@
// Top level of the block pool mailbox manager: controller plus datapath.
// Depends on bpm_pkg, bpm_channels, bpm_ctrl and bpm_dpath.
//
//   channel  | dir | word                                         | handshake
//   ---------+-----+----------------------------------------------+-------------
//   i_req    | in  | req_type, request_amount, reader_capacity    | valid/ready
//   o_rsp    | out | ok, block_index, amount_out                  | valid/ready
//
// A request's accept cycle reads the link memory, and for a read the amount
// memory, at the list head; the next cycle updates the heads, writes back at
// most one link entry and, for a write, one amount entry, and loads the result
// register. After reset a sweep over every entry chains the link memory into
// the free stack; no request is taken until it ends.
// A waiting result does not stall the next accept once it is taken in the
// same cycle; while o_rsp stays stalled, i_req is held off.
module block_pool_mailbox_manager_unit import bpm_pkg::*; #(
    parameter int BLOCK_COUNT = BPM_BLOCK_COUNT_DEF,
    parameter int BLOCK_SIZE  = BPM_BLOCK_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpm_req_if.sink    i_req,
    bpm_rsp_if.source  o_rsp
);

    // Command and status between the two halves
    t_bpm_cmd cmd;
    t_bpm_sts sts;

    // Sequence the clear sweep, the accept and the execute cycle
    bpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Hold the lists, the block memories and the result word
    bpm_dpath #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .BLOCK_SIZE  (BLOCK_SIZE)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_req_type        (i_req.req_type),
        .i_request_amount  (i_req.request_amount),
        .i_reader_capacity (i_req.reader_capacity),
        .o_out_valid       (o_rsp.valid),
        .i_out_ready       (o_rsp.ready),
        .o_ok              (o_rsp.ok),
        .o_block_index     (o_rsp.block_index),
        .o_amount_out      (o_rsp.amount_out)
    );

endmodule

@@ verif/bpm_mailbox_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the block pool mailbox manager: models the free stack and message queue.
// Depends on bpm_pkg and the channel interfaces in bpm_channels.
module bpm_mailbox_checker import bpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bpm_req_if   i_req,
    bpm_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_writes,
    output int   o_empty_reads
);

    localparam int         POOL_SIZE = BPM_BLOCK_COUNT_DEF;
    localparam int         BLK_BYTES = BPM_BLOCK_SIZE_DEF;
    localparam logic [4:0] NIL       = 5'(POOL_SIZE);
    localparam int         SHOWN_MAX = 10;

    typedef struct packed {
        logic                 ok;
        logic [IDX_W-1:0]     block;
        logic [AMT_OUT_W-1:0] bytes;
    } t_mbox_word;

    logic [4:0]           next_link   [POOL_SIZE];
    logic [AMT_OUT_W-1:0] block_bytes [POOL_SIZE];
    logic [4:0]           free_top;
    logic [4:0]           queue_first;
    logic [4:0]           queue_last;
    t_mbox_word           awaited_words [$];

    int fails       = 0;
    int checked     = 0;
    int full_writes = 0;
    int empty_reads = 0;

    task automatic init_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            next_link[i]   = 5'(i + 1);
            block_bytes[i] = '0;
        end
        free_top    = '0;
        queue_first = NIL;
        queue_last  = NIL;
    endtask

    // Pop a free block, clip the offer and append the block to the queue
    function automatic t_mbox_word post_block(logic [REQ_W-1:0] amount);
        t_mbox_word       w;
        logic [4:0]       blk;
        logic [IDX_W-1:0] slot;
        w   = '0;
        blk = free_top;
        if (blk >= NIL) begin
            full_writes++;
            return w;
        end
        slot     = blk[IDX_W-1:0];
        free_top = next_link[slot];
        w.ok     = 1'b1;
        w.block  = slot;
        w.bytes  = (amount < BLK_BYTES) ? AMT_OUT_W'(amount) : AMT_OUT_W'(BLK_BYTES);
        block_bytes[slot] = w.bytes;
        next_link[slot]   = NIL;
        if (queue_last < NIL)
            next_link[queue_last[IDX_W-1:0]] = blk;
        queue_last = blk;
        if (queue_first >= NIL)
            queue_first = blk;
        return w;
    endfunction

    // Pop the oldest posted block, limit by capacity and push it onto the free stack
    function automatic t_mbox_word take_block(logic [REQ_W-1:0] capacity);
        t_mbox_word       w;
        logic [4:0]       blk;
        logic [IDX_W-1:0] slot;
        w   = '0;
        blk = queue_first;
        if (blk >= NIL) begin
            empty_reads++;
            return w;
        end
        slot        = blk[IDX_W-1:0];
        queue_first = next_link[slot];
        if (blk == queue_last)
            queue_last = NIL;
        w.ok    = 1'b1;
        w.block = slot;
        w.bytes = (REQ_W'(block_bytes[slot]) < capacity) ? block_bytes[slot]
                                                         : AMT_OUT_W'(capacity);
        next_link[slot] = free_top;
        free_top        = blk;
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_mbox_word got;
        t_mbox_word want;
        if (!i_rst_n) begin
            init_pool();
            awaited_words.delete();
        end else begin
            // Responses first: a request taken at this edge cannot answer at once
            if (i_rsp.valid && i_rsp.ready) begin
                got.ok    = i_rsp.ok;
                got.block = i_rsp.block_index;
                got.bytes = i_rsp.amount_out;
                if (awaited_words.size() == 0) begin
                    fails++;
                    if (fails <= SHOWN_MAX)
                        $display("%0t: unexpected response word ok=%0d block=%0d bytes=%0d",
                                 $time, got.ok, got.block, got.bytes);
                end else begin
                    want = awaited_words.pop_front();
                    checked++;
                    if (got.ok !== want.ok || got.block !== want.block ||
                        got.bytes !== want.bytes) begin
                        fails++;
                        if (fails <= SHOWN_MAX)
                            $display("%0t: response mismatch: expected ok=%0d block=%0d bytes=%0d, actual ok=%0d block=%0d bytes=%0d",
                                     $time, want.ok, want.block, want.bytes,
                                     got.ok, got.block, got.bytes);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_WRITE)
                    awaited_words.push_back(post_block(i_req.request_amount));
                else
                    awaited_words.push_back(take_block(i_req.reader_capacity));
            end
        end
        o_fail_count  <= fails;
        o_pending     <= awaited_words.size();
        o_checked     <= checked;
        o_full_writes <= full_writes;
        o_empty_reads <= empty_reads;
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Top of the block pool mailbox manager testbench: clock, reset, request words and verdict.
// Depends on bpm_pkg, bpm_channels, the unit under test and bpm_mailbox_checker.
module testbench;
    import bpm_pkg::*;

    // Roughly 1850 random words spread over three pacing phases
    localparam int PHASE_WORDS = 616;
    // Watchdog limit; keep a wide margin over the slowest run
    localparam int CYCLE_LIMIT = 400000;
    // Drain time after the last response: the accept/execute pipeline plus slack
    localparam int TAIL_CYCLES = 8;

    logic clk;
    logic rst_n;

    // Percentages of cycles in which each side holds back
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    int cycle_count = 0;
    int sent_words  = 0;

    int fail_count;
    int pending_words;
    int checked_words;
    int full_writes;
    int empty_reads;

    // Offers used while filling the pool in the directed part
    logic [REQ_W-1:0] edge_amounts [16] = '{16'd0, 16'd1, 16'd4095, 16'd4096,
                                             16'd4097, 16'hFFFF, 16'h8000, 16'h7FFF,
                                             16'h5555, 16'hAAAA, 16'h0FFF, 16'hF000,
                                             16'd2048, 16'd100, 16'h00FF, 16'hFF00};

    bpm_req_if req_ch ();
    bpm_rsp_if rsp_ch ();

    block_pool_mailbox_manager_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bpm_mailbox_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending_words),
        .o_checked     (checked_words),
        .o_full_writes (full_writes),
        .o_empty_reads (empty_reads)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Response side: stall at random at the current receiver idle rate
    always @(posedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog: abandon the run if it hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Favour the boundaries of the clip and capacity compares, then anything at all
    function automatic logic [REQ_W-1:0] pick_size();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 16'd4096;
            2:       return 16'd4095;
            3:       return 16'd4097;
            4:       return 16'hFFFF;
            5:       return REQ_W'($urandom_range(4096));
            default: return REQ_W'($urandom_range(65535));
        endcase
    endfunction

    // Present one request word and hold it until the block takes it.
    // While idling, scramble the payload so that only valid qualifies it.
    task automatic send_word(t_req_type kind, logic [REQ_W-1:0] amount,
                             logic [REQ_W-1:0] capacity);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_ch.valid           <= 1'b0;
            req_ch.req_type        <= t_req_type'($urandom_range(1));
            req_ch.request_amount  <= REQ_W'($urandom_range(65535));
            req_ch.reader_capacity <= REQ_W'($urandom_range(65535));
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= kind;
        req_ch.request_amount  <= amount;
        req_ch.reader_capacity <= capacity;
        do @(posedge clk); while (!req_ch.ready);
        sent_words++;
    endtask

    // Drop valid and hold off until every predicted response has been seen.
    // Step the clock before the first check so the checker's count covers the last word taken.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
    endtask

    // Random traffic in bursts that lean to writes, reads or neither, so the
    // pool regularly fills up completely and the queue regularly runs dry
    task automatic run_traffic(int count);
        int        bias;
        t_req_type kind;
        bias = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(2))
                    0:       bias = 15;
                    1:       bias = 50;
                    default: bias = 85;
                endcase
            end
            kind = ($urandom_range(99) < bias) ? REQ_WRITE : REQ_READ;
            send_word(kind, pick_size(), pick_size());
        end
    endtask

    initial begin
        rst_n                  <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.req_type        <= REQ_WRITE;
        req_ch.request_amount  <= '0;
        req_ch.reader_capacity <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: read on an empty queue, a clipped write read straight back
        // so the tail clears, then another empty read
        send_word(REQ_READ, 16'hFFFF, 16'hFFFF);
        send_word(REQ_WRITE, 16'd4097, 16'h0000);
        send_word(REQ_READ, 16'h0000, 16'hFFFF);
        send_word(REQ_READ, 16'hFFFF, 16'd100);

        // Fill the whole pool with boundary offers, then one write too many
        for (int i = 0; i < 16; i++)
            send_word(REQ_WRITE, edge_amounts[i], 16'hFFFF);
        send_word(REQ_WRITE, 16'd10, 16'd10);

        // Reads with zero, full, just-below-block and minimal capacity
        send_word(REQ_READ, 16'hFFFF, 16'd0);
        send_word(REQ_READ, 16'h0000, 16'hFFFF);
        send_word(REQ_READ, 16'h0000, 16'd4095);
        send_word(REQ_READ, 16'hFFFF, 16'd1);
        wait_for_drain();

        // Sender idles less than the receiver
        snd_idle_pct = 35;
        rcv_idle_pct = 47;
        run_traffic(PHASE_WORDS);
        wait_for_drain();

        // Receiver idles less than the sender
        snd_idle_pct = 47;
        rcv_idle_pct = 35;
        run_traffic(PHASE_WORDS);
        wait_for_drain();

        // Full rate both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_traffic(PHASE_WORDS);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d request words and %0d checked responses over three pacing phases",
                 sent_words, checked_words);
        $display("Refused writes on a full pool: %0d, refused reads on an empty queue: %0d",
                 full_writes, empty_reads);
        if (fail_count == 0 && pending_words == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bpm_pkg.sv
rtl/bpm_channels.sv
rtl/bpm_ctrl.sv
rtl/bpm_dpath.sv
rtl/block_pool_mailbox_manager_unit.sv
verif/bpm_mailbox_checker.sv
verif/testbench.sv
